// ===== design/itpt_pkg.sv =====
// Shared constants, types and a helper function for the integer-to-padded-text block.
package itpt_pkg;

    // Operand and field widths.
    localparam int VALUE_BITS  = 64;
    localparam int DIGIT_SLOTS = 22;
    localparam int BCD_DIGITS  = 20;
    localparam int POS_W       = 5;
    localparam int STEP_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 8;

    // Radix codes.
    localparam logic [1:0] RADIX_OCT    = 2'd0;
    localparam logic [1:0] RADIX_DEC    = 2'd1;
    localparam logic [1:0] RADIX_HEX_UP = 2'd2;
    localparam logic [1:0] RADIX_HEX_LO = 2'd3;

    // Position of the most significant digit slot for each radix.
    localparam logic [POS_W-1:0] POS_TOP_OCT = 5'd21;
    localparam logic [POS_W-1:0] POS_TOP_DEC = 5'd19;
    localparam logic [POS_W-1:0] POS_TOP_HEX = 5'd15;

    // Number of double-dabble steps, minus one.
    localparam logic [STEP_W-1:0] CONV_LAST_STEP = 6'd63;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Piece of text the controller offers to the run merger.
    typedef enum logic [2:0] {
        PIECE_NONE      = 3'd0,
        PIECE_PAD_SPACE = 3'd1,
        PIECE_SIGN      = 3'd2,
        PIECE_PAD_ZERO  = 3'd3,
        PIECE_DIGIT     = 3'd4
    } t_piece;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   conv_step;
        logic   scan_step;
        logic   latch_pad;
        t_piece piece;
        logic   flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic scan_done;
        logic piece_taken;
        logic pos_zero;
        logic flush_done;
        logic left;
        logic zpad;
    } t_status;

    // ASCII character for one digit value.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic lower);
        logic [CHAR_W-1:0] alpha;
        alpha = lower ? CH_LO_A : CH_UP_A;
        if (d < 4'd10) begin
            return CH_ZERO + {4'b0000, d};
        end
        return alpha + {4'b0000, d} - 8'd10;
    endfunction

endpackage

// ===== design/itpt_ctrl.sv =====
// Sequencer that steps one word through conversion, digit scan and run emission.
module itpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  itpt_pkg::t_status i_sts,
    output itpt_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CONV  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_PRE   = 9'b000001000,
        S_SIGN  = 9'b000010000,
        S_ZERO  = 9'b000100000,
        S_DIGIT = 9'b001000000,
        S_POST  = 9'b010000000,
        S_FLUSH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.piece = itpt_pkg::PIECE_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.latch_pad = 1'b1;
                    n_state = (i_sts.left || i_sts.zpad) ? S_SIGN : S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.piece = itpt_pkg::PIECE_PAD_SPACE;
                if (i_sts.piece_taken) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                o_cmd.piece = itpt_pkg::PIECE_SIGN;
                if (i_sts.piece_taken) begin
                    n_state = (i_sts.zpad && !i_sts.left) ? S_ZERO : S_DIGIT;
                end
            end
            S_ZERO: begin
                o_cmd.piece = itpt_pkg::PIECE_PAD_ZERO;
                if (i_sts.piece_taken) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                o_cmd.piece = itpt_pkg::PIECE_DIGIT;
                if (i_sts.piece_taken && i_sts.pos_zero) begin
                    n_state = i_sts.left ? S_POST : S_FLUSH;
                end
            end
            S_POST: begin
                o_cmd.piece = itpt_pkg::PIECE_PAD_SPACE;
                if (i_sts.piece_taken) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_sts.flush_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new word is taken only between words.
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== design/itpt_dpath.sv =====
// Datapath: magnitude, double-dabble converter, digit store, run merger and output register.
module itpt_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  itpt_pkg::t_cmd                      i_cmd,
    output itpt_pkg::t_status                   o_sts,
    input  logic [itpt_pkg::VALUE_BITS-1:0]     i_value,
    input  logic                                i_is_signed,
    input  logic [1:0]                          i_radix,
    input  logic                                i_show_plus,
    input  logic                                i_show_space,
    input  logic [itpt_pkg::COUNT_W-1:0]        i_width,
    input  logic                                i_left_justify,
    input  logic                                i_zero_pad,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [itpt_pkg::CHAR_W-1:0]         o_character,
    output logic [itpt_pkg::COUNT_W-1:0]        o_repeat_count,
    output logic                                o_last
);

    localparam int DIG_BITS = 4 * itpt_pkg::DIGIT_SLOTS;
    localparam int BCD_BITS = 4 * itpt_pkg::BCD_DIGITS;
    localparam int OCT_BITS = 3 * itpt_pkg::DIGIT_SLOTS;

    // Word registers.
    logic [itpt_pkg::VALUE_BITS-1:0] r_bin;
    logic [DIG_BITS-1:0]             r_digs;
    logic [itpt_pkg::POS_W-1:0]      r_pos;
    logic [itpt_pkg::STEP_W-1:0]     r_step;
    logic                            r_dec;
    logic                            r_lower;
    logic                            r_left;
    logic                            r_zpad;
    logic [itpt_pkg::COUNT_W-1:0]    r_width;
    logic [itpt_pkg::COUNT_W-1:0]    r_pad;
    logic                            r_has_sign;
    logic [itpt_pkg::CHAR_W-1:0]     r_sign_ch;

    // Pending run and output register.
    logic                            r_pend_valid;
    logic [itpt_pkg::CHAR_W-1:0]     r_pend_ch;
    logic [itpt_pkg::COUNT_W-1:0]    r_pend_cnt;
    logic                            r_out_valid;
    logic [itpt_pkg::CHAR_W-1:0]     r_out_ch;
    logic [itpt_pkg::COUNT_W-1:0]    r_out_cnt;
    logic                            r_out_last;

    logic                            negative;
    logic [itpt_pkg::VALUE_BITS-1:0] mag;
    logic [OCT_BITS-1:0]             mag_ext;
    logic [DIG_BITS-1:0]             oct_digs;
    logic [BCD_BITS-1:0]             bcd_adj;
    logic [3:0]                      cur_dig;
    logic [itpt_pkg::COUNT_W-1:0]    text_len;
    logic [itpt_pkg::POS_W-1:0]      top_pos;
    logic                            scan_done;
    logic [itpt_pkg::CHAR_W-1:0]     piece_ch;
    logic [itpt_pkg::COUNT_W-1:0]    piece_n;
    logic                            piece_active;
    logic                            slot_free;
    logic                            merge;
    logic                            taken;
    logic                            piece_real;
    logic                            pend_to_out;
    logic                            flush_go;

    // Magnitude of the operand; the most negative value maps onto itself.
    assign negative = i_is_signed && i_value[itpt_pkg::VALUE_BITS-1];
    assign mag      = negative ? (~i_value + 64'd1) : i_value;
    assign mag_ext  = {{(OCT_BITS - itpt_pkg::VALUE_BITS){1'b0}}, mag};

    // Octal digits spread out to one nibble each.
    always_comb begin
        for (int i = 0; i < itpt_pkg::DIGIT_SLOTS; i++) begin
            oct_digs[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
        end
    end

    // Highest digit slot for the chosen radix.
    always_comb begin
        unique case (i_radix)
            itpt_pkg::RADIX_OCT: top_pos = itpt_pkg::POS_TOP_OCT;
            itpt_pkg::RADIX_DEC: top_pos = itpt_pkg::POS_TOP_DEC;
            default:             top_pos = itpt_pkg::POS_TOP_HEX;
        endcase
    end

    // Add-three correction of every BCD digit before the next shift.
    always_comb begin
        for (int i = 0; i < itpt_pkg::BCD_DIGITS; i++) begin
            if (r_digs[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_digs[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_digs[4*i +: 4];
            end
        end
    end

    // Digit under the scan and emit pointer.
    assign cur_dig   = r_digs[{r_pos, 2'b00} +: 4];
    assign scan_done = (cur_dig != 4'd0) || (r_pos == '0);
    assign text_len  = {3'b000, r_pos} + 8'd1 + {7'b0000000, r_has_sign};

    // Character and repeat count of the offered piece.
    always_comb begin
        unique case (i_cmd.piece)
            itpt_pkg::PIECE_PAD_SPACE: begin
                piece_ch = itpt_pkg::CH_SPACE;
                piece_n  = r_pad;
            end
            itpt_pkg::PIECE_SIGN: begin
                piece_ch = r_sign_ch;
                piece_n  = {7'b0000000, r_has_sign};
            end
            itpt_pkg::PIECE_PAD_ZERO: begin
                piece_ch = itpt_pkg::CH_ZERO;
                piece_n  = r_pad;
            end
            itpt_pkg::PIECE_DIGIT: begin
                piece_ch = itpt_pkg::digit_char(cur_dig, r_lower);
                piece_n  = 8'd1;
            end
            default: begin
                piece_ch = '0;
                piece_n  = '0;
            end
        endcase
    end

    // Run merging: equal neighbors add up, a new character pushes the pending run out.
    assign piece_active = (i_cmd.piece != itpt_pkg::PIECE_NONE);
    assign slot_free    = !r_out_valid || !i_out_stall;
    assign merge        = r_pend_valid && (r_pend_ch == piece_ch);
    assign taken        = piece_active &&
                          ((piece_n == '0) || merge || !r_pend_valid || slot_free);
    assign piece_real   = taken && (piece_n != '0);
    assign pend_to_out  = piece_real && !merge && r_pend_valid;
    assign flush_go     = i_cmd.flush && slot_free;

    // Word registers: load, conversion, scan and digit walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin      <= mag;
            r_pos      <= top_pos;
            r_step     <= itpt_pkg::CONV_LAST_STEP;
            r_dec      <= (i_radix == itpt_pkg::RADIX_DEC);
            r_lower    <= (i_radix == itpt_pkg::RADIX_HEX_LO);
            r_left     <= i_left_justify;
            r_zpad     <= i_zero_pad;
            r_width    <= i_width;
            r_has_sign <= negative || (i_is_signed && (i_show_plus || i_show_space));
            r_sign_ch  <= negative ? itpt_pkg::CH_MINUS :
                          (i_show_plus ? itpt_pkg::CH_PLUS : itpt_pkg::CH_SPACE);
            case (i_radix)
                itpt_pkg::RADIX_OCT: r_digs <= oct_digs;
                itpt_pkg::RADIX_DEC: r_digs <= '0;
                default:             r_digs <= {{(DIG_BITS - itpt_pkg::VALUE_BITS){1'b0}}, mag};
            endcase
        end else begin
            if (i_cmd.conv_step && r_dec) begin
                r_digs[BCD_BITS-1:0] <= {bcd_adj[BCD_BITS-2:0], r_bin[itpt_pkg::VALUE_BITS-1]};
                r_bin                <= {r_bin[itpt_pkg::VALUE_BITS-2:0], 1'b0};
                r_step               <= r_step - 6'd1;
            end
            if (i_cmd.scan_step && !scan_done) begin
                r_pos <= r_pos - 5'd1;
            end
            if (i_cmd.latch_pad) begin
                r_pad <= (r_width > text_len) ? (r_width - text_len) : '0;
            end
            if (taken && (i_cmd.piece == itpt_pkg::PIECE_DIGIT) && (r_pos != '0)) begin
                r_pos <= r_pos - 5'd1;
            end
        end
    end

    // Valid flags of the pending run and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pend_to_out || flush_go) begin
                r_out_valid <= 1'b1;
            end
            if (piece_real) begin
                r_pend_valid <= 1'b1;
            end else if (flush_go) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Run payloads.
    always_ff @(posedge i_clk) begin
        if (piece_real) begin
            if (merge) begin
                r_pend_cnt <= r_pend_cnt + piece_n;
            end else begin
                r_pend_ch  <= piece_ch;
                r_pend_cnt <= piece_n;
            end
        end
        if (pend_to_out || flush_go) begin
            r_out_ch   <= r_pend_ch;
            r_out_cnt  <= r_pend_cnt;
            r_out_last <= flush_go;
        end
    end

    // Status back to the controller.
    assign o_sts.conv_done   = !r_dec || (r_step == '0);
    assign o_sts.scan_done   = scan_done;
    assign o_sts.piece_taken = taken;
    assign o_sts.pos_zero    = (r_pos == '0);
    assign o_sts.flush_done  = slot_free;
    assign o_sts.left        = r_left;
    assign o_sts.zpad        = r_zpad;

    assign o_out_valid    = r_out_valid;
    assign o_character    = r_out_ch;
    assign o_repeat_count = r_out_cnt;
    assign o_last         = r_out_last;

    // A run handed out is never empty.
    ast_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt != '0))
        else $error("output run has a zero repeat count");

    // A pending run is never empty.
    ast_pend_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pend_cnt != '0))
        else $error("pending run has a zero repeat count");

    // Two neighboring runs of one word never carry the same character.
    ast_runs_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last && r_pend_valid) |-> (r_pend_ch != r_out_ch))
        else $error("adjacent runs share a character");

    // The final run exists when the controller asks for it.
    ast_flush_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> r_pend_valid)
        else $error("flush requested with no pending run");

endmodule

// ===== design/integer_to_padded_text.sv =====
// Top level of the printf-style integer to run-length text converter.
// One word in carries a 64-bit integer with its radix and format flags; the block answers
// with runs of (character, repeat count), equal neighbors merged, the final run flagged by
// o_last. Words are handled one at a time: o_in_stall stays high from acceptance until the
// final run has entered the output register. A word passes through a load step, a conversion
// (digits loaded directly for octal and hex, serial double-dabble for decimal), a leading-zero scan from the top
// digit slot (22 slots for octal, 20 for decimal, 16 for hex) down to the leading digit at
// one slot per cycle, the digits one at a time, a sign piece and one padding piece, and a
// final flush. Scan and digit steps together are fixed by the slot count, so without output
// stalls the time a word takes depends only on its radix, not on its value; a run that waits
// on a stalled output adds its waiting cycles.
// The output register lets the next run form while the previous one waits to be taken.
module integer_to_padded_text (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [itpt_pkg::VALUE_BITS-1:0] i_value,
    input  logic                            i_is_signed,
    input  logic [1:0]                      i_radix,
    input  logic                            i_show_plus,
    input  logic                            i_show_space,
    input  logic [itpt_pkg::COUNT_W-1:0]    i_width,
    input  logic                            i_left_justify,
    input  logic                            i_zero_pad,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [itpt_pkg::CHAR_W-1:0]     o_character,
    output logic [itpt_pkg::COUNT_W-1:0]    o_repeat_count,
    output logic                            o_last
);

    itpt_pkg::t_cmd    cmd;
    itpt_pkg::t_status sts;

    // Sequencer.
    itpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Conversion and run datapath.
    itpt_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_value        (i_value),
        .i_is_signed    (i_is_signed),
        .i_radix        (i_radix),
        .i_show_plus    (i_show_plus),
        .i_show_space   (i_show_space),
        .i_width        (i_width),
        .i_left_justify (i_left_justify),
        .i_zero_pad     (i_zero_pad),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_character    (o_character),
        .o_repeat_count (o_repeat_count),
        .o_last         (o_last)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the integer to run-length text converter.
module testbench;
    import itpt_pkg::*;

    localparam int CLK_HIGH    = 6;
    localparam int CLK_LOW     = 6;
    localparam int RESET_LEN   = 8;
    localparam int RANDOM_WORDS = 400;
    localparam int HOLD_OFF    = 400;
    localparam int DRAIN_WAIT  = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 100;

    // One input word: the integer and its format flags.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  is_signed;
        logic [1:0]            radix;
        logic                  show_plus;
        logic                  show_space;
        logic [COUNT_W-1:0]    width;
        logic                  left;
        logic                  zpad;
    } t_int_word;

    // One output word: a run of equal characters.
    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_text_run;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [VALUE_BITS-1:0] i_value        = '0;
    logic                  i_is_signed    = 1'b0;
    logic [1:0]            i_radix        = RADIX_OCT;
    logic                  i_show_plus    = 1'b0;
    logic                  i_show_space   = 1'b0;
    logic [COUNT_W-1:0]    i_width        = '0;
    logic                  i_left_justify = 1'b0;
    logic                  i_zero_pad     = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [CHAR_W-1:0]     o_character;
    logic [COUNT_W-1:0]    o_repeat_count;
    logic                  o_last;

    t_text_run expected_runs[$];
    t_int_word directed_words[$];
    string     directed_texts[$];
    int        error_count = 0;
    int        runs_seen   = 0;
    int        cycle_count = 0;
    int        load_phase  = 0;
    int        hold_left   = 0;
    bit        hold_done   = 1'b0;

    integer_to_padded_text DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_is_signed    (i_is_signed),
        .i_radix        (i_radix),
        .i_show_plus    (i_show_plus),
        .i_show_space   (i_show_space),
        .i_width        (i_width),
        .i_left_justify (i_left_justify),
        .i_zero_pad     (i_zero_pad),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_character    (o_character),
        .o_repeat_count (o_repeat_count),
        .o_last         (o_last)
    );

    // Free-running clock.
    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // Counts one mismatch and prints a line for it while under the report limit.
    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("mismatch at run %0d: %s", runs_seen, what);
        end
        error_count++;
    endtask

    // Formats the integer as printf would, padding included.
    function automatic string format_text(input t_int_word w);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] base;
        logic [3:0]            digit;
        logic [CHAR_W-1:0]     ch;
        string                 digits;
        string                 sign;
        string                 padding;
        byte                   pad_char;
        int                    pad;
        mag = w.value;
        sign = "";
        if (w.is_signed) begin
            if (mag[VALUE_BITS-1]) begin
                sign = string'(CH_MINUS);
                mag = -mag;
            end else if (w.show_plus) begin
                sign = string'(CH_PLUS);
            end else if (w.show_space) begin
                sign = string'(CH_SPACE);
            end
        end
        case (w.radix)
            RADIX_OCT: base = 64'd8;
            RADIX_DEC: base = 64'd10;
            default:   base = 64'd16;
        endcase
        // Digits come out least significant first, so prepend each one.
        digits = "";
        do begin
            digit = 4'(mag % base);
            if (digit < 4'd10) begin
                ch = CH_ZERO + CHAR_W'(digit);
            end else if (w.radix == RADIX_HEX_LO) begin
                ch = CH_LO_A + CHAR_W'(digit) - 8'd10;
            end else begin
                ch = CH_UP_A + CHAR_W'(digit) - 8'd10;
            end
            digits = {string'(ch), digits};
            mag = mag / base;
        end while (mag != 0);
        pad = int'(w.width) - digits.len() - sign.len();
        pad_char = (!w.left && w.zpad) ? CH_ZERO : CH_SPACE;
        padding = "";
        for (int i = 0; i < pad; i++) begin
            padding = {padding, string'(pad_char)};
        end
        if (w.left) begin
            return {sign, digits, padding};
        end else if (w.zpad) begin
            return {sign, padding, digits};
        end
        return {padding, sign, digits};
    endfunction

    // Splits text into maximal runs and queues them as expected words.
    task automatic queue_runs(input string text);
        byte ch;
        int  n;
        ch = text[0];
        n = 1;
        for (int i = 1; i < text.len(); i++) begin
            if (text[i] == ch) begin
                n++;
            end else begin
                expected_runs.push_back('{ch, COUNT_W'(n), 1'b0});
                ch = text[i];
                n = 1;
            end
        end
        expected_runs.push_back('{ch, COUNT_W'(n), 1'b1});
    endtask

    // Offers one word after a random gap and queues its runs once taken.
    // A blank text means the expected runs come from the formatter.
    task automatic send_word(input t_int_word w, input string text, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_value        <= w.value;
        i_is_signed    <= w.is_signed;
        i_radix        <= w.radix;
        i_show_plus    <= w.show_plus;
        i_show_space   <= w.show_space;
        i_width        <= w.width;
        i_left_justify <= w.left;
        i_zero_pad     <= w.zpad;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        queue_runs(text == "" ? format_text(w) : text);
    endtask

    // One directed row.
    task automatic add_row(input logic [63:0] value, input logic sgn, input logic [1:0] radix,
                           input logic plus, input logic space, input logic [7:0] width,
                           input logic left, input logic zpad, input string text);
        directed_words.push_back('{value, sgn, radix, plus, space, width, left, zpad});
        directed_texts.push_back(text);
    endtask

    // Random word, biased toward short values and narrow fields.
    function automatic t_int_word random_word();
        t_int_word w;
        int        kind;
        w.value = {$urandom(), $urandom()};
        kind = $urandom_range(9);
        case (kind)
            0:       w.value = 64'($urandom_range(20));
            1:       w.value = {~w.value[0], {63{w.value[0]}}} ^ 64'($urandom_range(3));
            2, 3, 4: w.value = w.value >> $urandom_range(63);
            5:       w.value = -(w.value >> $urandom_range(63));
            default: ;
        endcase
        w.is_signed  = 1'($urandom_range(1));
        w.radix      = 2'($urandom_range(3));
        w.show_plus  = 1'($urandom_range(1));
        w.show_space = 1'($urandom_range(1));
        w.left       = 1'($urandom_range(1));
        w.zpad       = 1'($urandom_range(1));
        kind = $urandom_range(19);
        if (kind == 0) begin
            w.width = 8'd255;
        end else if (kind < 4) begin
            w.width = 8'($urandom_range(255));
        end else begin
            w.width = 8'($urandom_range(30));
        end
        return w;
    endfunction

    // Output side: random stall, plus one long hold-off that fills the block.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (load_phase == 2 && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_OFF;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < (load_phase == 0 ? 82 :
                                                 load_phase == 1 ? 11 : 0));
        end
    end

    // Compare every accepted run with the oldest expectation.
    always @(posedge i_clk) begin
        t_text_run want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_runs.size() == 0) begin
                report_mismatch($sformatf("unexpected run char %h count %0d last %b",
                                          o_character, o_repeat_count, o_last));
            end else begin
                want = expected_runs.pop_front();
                if (o_character !== want.character) begin
                    report_mismatch($sformatf("character %h, expected %h",
                                              o_character, want.character));
                end
                if (o_repeat_count !== want.count) begin
                    report_mismatch($sformatf("repeat count %0d, expected %0d",
                                              o_repeat_count, want.count));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                end
            end
            runs_seen++;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Reset, directed rows, random words in three load phases, then drain.
    initial begin
        //       value                  sgn radix         +  sp width   lj zp  text
        add_row(64'h0,                  0, RADIX_DEC,    0, 0, 8'd0,   0, 0, "0");
        add_row(64'hFFFFFFFFFFFFFFFF,   0, RADIX_DEC,    0, 0, 8'd0,   0, 0,
                "18446744073709551615");
        add_row(64'hFFFFFFFFFFFFFFFF,   0, RADIX_OCT,    0, 0, 8'd5,   0, 1,
                "1777777777777777777777");
        add_row(64'hFFFFFFFFFFFFFFFF,   0, RADIX_HEX_UP, 1, 1, 8'd0,   0, 0,
                "FFFFFFFFFFFFFFFF");
        add_row(64'hFFFFFFFFFFFFFFFF,   0, RADIX_HEX_LO, 0, 0, 8'd0,   0, 0,
                "ffffffffffffffff");
        add_row(64'h8000000000000000,   1, RADIX_DEC,    0, 0, 8'd0,   0, 0,
                "-9223372036854775808");
        add_row(64'h8000000000000000,   1, RADIX_OCT,    1, 0, 8'd0,   0, 0,
                "-1000000000000000000000");
        add_row(64'h8000000000000000,   1, RADIX_HEX_LO, 0, 1, 8'd0,   0, 0,
                "-8000000000000000");
        add_row(64'h8000000000000000,   0, RADIX_DEC,    0, 0, 8'd0,   0, 0,
                "9223372036854775808");
        add_row(64'hFFFFFFFFFFFFFFFF,   1, RADIX_DEC,    0, 0, 8'd0,   0, 0, "-1");
        add_row(64'h7FFFFFFFFFFFFFFF,   1, RADIX_DEC,    1, 0, 8'd0,   0, 0,
                "+9223372036854775807");
        add_row(64'd42,                 1, RADIX_DEC,    0, 1, 8'd0,   0, 0, " 42");
        add_row(64'd42,                 1, RADIX_DEC,    1, 1, 8'd0,   0, 0, "+42");
        add_row(64'd42,                 0, RADIX_DEC,    1, 1, 8'd0,   0, 0, "42");
        add_row(64'hFFFFFFFFFFFFFFD6,   1, RADIX_DEC,    0, 0, 8'd6,   0, 1, "-00042");
        add_row(64'hFFFFFFFFFFFFFFD6,   1, RADIX_DEC,    0, 0, 8'd6,   0, 0, "   -42");
        add_row(64'hFFFFFFFFFFFFFFD6,   1, RADIX_DEC,    0, 0, 8'd6,   1, 1, "-42   ");
        add_row(64'd255,                0, RADIX_HEX_LO, 0, 0, 8'd4,   0, 1, "00ff");
        add_row(64'd100,                0, RADIX_DEC,    0, 0, 8'd0,   0, 0, "100");
        add_row(64'd0,                  1, RADIX_DEC,    0, 1, 8'd3,   0, 0, "  0");
        // Full-width fields: merged runs of padding, checked by the formatter.
        add_row(64'd0,                  0, RADIX_OCT,    0, 0, 8'd255, 0, 1, "");
        add_row(64'd0,                  1, RADIX_DEC,    1, 0, 8'd255, 0, 1, "");
        add_row(64'd0,                  1, RADIX_HEX_UP, 0, 1, 8'd255, 0, 0, "");
        add_row(64'hFFFFFFFFFFFFFFFF,   1, RADIX_HEX_UP, 0, 0, 8'd255, 1, 0, "");
        add_row(64'h0123456789ABCDEF,   0, RADIX_HEX_LO, 0, 0, 8'd254, 0, 0, "");

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i]) begin
            send_word(directed_words[i], directed_texts[i], 11);
        end
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            load_phase = i * 3 / RANDOM_WORDS;
            send_word(random_word(), "", load_phase == 0 ? 11 : load_phase == 1 ? 82 : 0);
        end
        i_in_valid <= 1'b0;

        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
